// File: hw/rtl/ucp_pkg.sv
// ----------------------------------------------------------------------------
// ucp_pkg
// Shared types, codes and constants of the unified camera projection block.
// ----------------------------------------------------------------------------
package ucp_pkg;

  localparam int unsigned BORDER_MARGIN = 10;
  localparam int unsigned SQRT_STAGES   = 32;
  // one overflow stage plus one stage per quotient bit
  localparam int unsigned QUOT_BITS     = 26;
  localparam int unsigned DIV_STAGES    = QUOT_BITS + 1;
  localparam int unsigned LATENCY       = 3 + SQRT_STAGES + 3 + DIV_STAGES + 2;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_DEPTH  = 2'd1,
    ST_MARGIN = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    CFG_FOCAL_X      = 3'd0,
    CFG_FOCAL_Y      = 3'd1,
    CFG_CENTER_X     = 3'd2,
    CFG_CENTER_Y     = 3'd3,
    CFG_MIRROR_XI    = 3'd4,
    CFG_IMAGE_WIDTH  = 3'd5,
    CFG_IMAGE_HEIGHT = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
    logic [2:0]         pyramid_level;
  } in_item_t;

  typedef struct packed {
    status_e     status;
    logic [23:0] pixel_u;
    logic [23:0] pixel_v;
  } out_item_t;

endpackage

// File: hw/rtl/ucp_isqrt.sv
// ----------------------------------------------------------------------------
// ucp_isqrt
// Pipelined integer square root of a 64-bit value, one result bit per stage.
// ----------------------------------------------------------------------------
module ucp_isqrt (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [63:0] sum_i,
  output logic [31:0] root_o
);

  logic [63:0] n_q    [ucp_pkg::SQRT_STAGES];
  logic [31:0] root_q [ucp_pkg::SQRT_STAGES];
  logic [32:0] rem_q  [ucp_pkg::SQRT_STAGES];

  for (genvar k = 0; k < ucp_pkg::SQRT_STAGES; k++) begin : g_stage
    logic [63:0] n_p;
    logic [31:0] root_p;
    logic [32:0] rem_p;
    logic [34:0] rem_sh;
    logic [34:0] trial;
    logic        ge;

    if (k == 0) begin : g_first
      assign n_p    = sum_i;
      assign root_p = '0;
      assign rem_p  = '0;
    end else begin : g_next
      assign n_p    = n_q[k-1];
      assign root_p = root_q[k-1];
      assign rem_p  = rem_q[k-1];
    end

    assign rem_sh = {rem_p, n_p[63:62]};
    assign trial  = {1'b0, root_p, 2'b01};
    assign ge     = rem_sh >= trial;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        n_q[k]    <= {n_p[61:0], 2'b00};
        root_q[k] <= {root_p[30:0], ge};
        rem_q[k]  <= ge ? 33'(rem_sh - trial) : rem_sh[32:0];
      end
    end
  end

  assign root_o = root_q[ucp_pkg::SQRT_STAGES-1];

endmodule

// File: hw/rtl/ucp_divider.sv
// ----------------------------------------------------------------------------
// ucp_divider
// Pipelined restoring divider with an overflow flag for quotients that do not fit.
// ----------------------------------------------------------------------------
module ucp_divider (
  input  logic                           clk_i,
  input  logic                           en_i,
  input  logic [57:0]                    dividend_i,
  input  logic [35:0]                    divisor_i,
  output logic [ucp_pkg::QUOT_BITS-1:0]  quot_o,
  output logic                           ovf_o
);

  localparam int unsigned QB = ucp_pkg::QUOT_BITS;

  logic [35:0]   rem_q  [ucp_pkg::DIV_STAGES];
  logic [QB-1:0] low_q  [ucp_pkg::DIV_STAGES];
  logic [QB-1:0] quot_q [ucp_pkg::DIV_STAGES];
  logic [35:0]   dsr_q  [ucp_pkg::DIV_STAGES];
  logic          ovf_q  [ucp_pkg::DIV_STAGES];

  // first stage: quotient would not fit when the top part already reaches the divisor
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0]  <= 36'(dividend_i[57:QB]);
      low_q[0]  <= dividend_i[QB-1:0];
      quot_q[0] <= '0;
      dsr_q[0]  <= divisor_i;
      ovf_q[0]  <= 36'(dividend_i[57:QB]) >= divisor_i;
    end
  end

  for (genvar k = 1; k < ucp_pkg::DIV_STAGES; k++) begin : g_stage
    logic [36:0] rem_sh;
    logic        ge;

    assign rem_sh = {rem_q[k-1], low_q[k-1][QB-1]};
    assign ge     = rem_sh >= {1'b0, dsr_q[k-1]};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= ge ? 36'(rem_sh - {1'b0, dsr_q[k-1]}) : rem_sh[35:0];
        low_q[k]  <= {low_q[k-1][QB-2:0], 1'b0};
        quot_q[k] <= {quot_q[k-1][QB-2:0], ge};
        dsr_q[k]  <= dsr_q[k-1];
        ovf_q[k]  <= ovf_q[k-1];
      end
    end
  end

  assign quot_o = quot_q[ucp_pkg::DIV_STAGES-1];
  assign ovf_o  = ovf_q[ucp_pkg::DIV_STAGES-1];

endmodule

// File: hw/rtl/unified_camera_projection.sv
// ----------------------------------------------------------------------------
// unified_camera_projection
// Unified omnidirectional camera projection of Q16.16 points to Q16.8 pixels.
// ----------------------------------------------------------------------------
// One point enters per cycle while the pipeline is not held; its path runs
// through the 32-stage square root and the 27-stage divider pair.
// The whole pipeline advances together and holds when the output register
// is full and not taken, so in_ready_o is low only while a result waits.
// Configuration is written through cfg_we_i / cfg_idx_i / cfg_wdata_i while
// no point is in flight; indices beyond image_height are ignored.
module unified_camera_projection (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_idx_i,
  input  logic [23:0]        cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  ucp_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output ucp_pkg::out_item_t out_data_o
);

  localparam int unsigned LAT = ucp_pkg::LATENCY;

  typedef struct packed {
    logic [31:0] az;
    logic [55:0] num_x;
    logic [55:0] num_y;
    logic        x_neg;
    logic        y_neg;
    logic [2:0]  lvl;
    logic        depth_bad;
  } side_t;

  typedef struct packed {
    logic       x_neg;
    logic       y_neg;
    logic [2:0] lvl;
    logic       depth_bad;
  } flag_t;

  // configuration registers
  logic [23:0] focal_x_q, focal_y_q, center_x_q, center_y_q;
  logic [15:0] mirror_xi_q;
  logic [13:0] image_width_q, image_height_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      focal_x_q      <= 24'd128000;
      focal_y_q      <= 24'd128000;
      center_x_q     <= 24'd81920;
      center_y_q     <= 24'd61440;
      mirror_xi_q    <= 16'd16384;
      image_width_q  <= 14'd640;
      image_height_q <= 14'd480;
    end else if (cfg_we_i) begin
      case (ucp_pkg::cfg_idx_e'(cfg_idx_i))
        ucp_pkg::CFG_FOCAL_X:      focal_x_q      <= cfg_wdata_i;
        ucp_pkg::CFG_FOCAL_Y:      focal_y_q      <= cfg_wdata_i;
        ucp_pkg::CFG_CENTER_X:     center_x_q     <= cfg_wdata_i;
        ucp_pkg::CFG_CENTER_Y:     center_y_q     <= cfg_wdata_i;
        ucp_pkg::CFG_MIRROR_XI:    mirror_xi_q    <= cfg_wdata_i[15:0];
        ucp_pkg::CFG_IMAGE_WIDTH:  image_width_q  <= cfg_wdata_i[13:0];
        ucp_pkg::CFG_IMAGE_HEIGHT: image_height_q <= cfg_wdata_i[13:0];
        default: ;
      endcase
    end
  end

  // global advance and valid chain
  logic           en;
  logic [LAT-1:0] vld_q;

  assign en          = !vld_q[LAT-1] || out_ready_i;
  assign in_ready_o  = en;
  assign out_valid_o = vld_q[LAT-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[LAT-2:0], in_valid_i};
    end
  end

  // stage a: magnitudes and depth test
  logic [31:0] a_ax_q, a_ay_q, a_az_q;
  logic        a_xn_q, a_yn_q, a_bad_q;
  logic [2:0]  a_lvl_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_ax_q  <= in_data_i.point_x[31] ? 32'(-in_data_i.point_x) : in_data_i.point_x;
      a_ay_q  <= in_data_i.point_y[31] ? 32'(-in_data_i.point_y) : in_data_i.point_y;
      a_az_q  <= in_data_i.point_z[31] ? 32'(-in_data_i.point_z) : in_data_i.point_z;
      a_xn_q  <= in_data_i.point_x[31];
      a_yn_q  <= in_data_i.point_y[31];
      a_bad_q <= in_data_i.point_z < 32'sd66;
      a_lvl_q <= in_data_i.pyramid_level;
    end
  end

  // stage b: squares and focal products
  logic [63:0] b_sqx_q, b_sqy_q, b_sqz_q;
  side_t       b_side_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      b_sqx_q              <= 64'(a_ax_q) * 64'(a_ax_q);
      b_sqy_q              <= 64'(a_ay_q) * 64'(a_ay_q);
      b_sqz_q              <= 64'(a_az_q) * 64'(a_az_q);
      b_side_q.az          <= a_az_q;
      b_side_q.num_x       <= 56'(focal_x_q) * 56'(a_ax_q);
      b_side_q.num_y       <= 56'(focal_y_q) * 56'(a_ay_q);
      b_side_q.x_neg       <= a_xn_q;
      b_side_q.y_neg       <= a_yn_q;
      b_side_q.lvl         <= a_lvl_q;
      b_side_q.depth_bad   <= a_bad_q;
    end
  end

  // stage c: sum of squares
  logic [63:0] c_sum_q;
  side_t       c_side_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      c_sum_q  <= b_sqx_q + b_sqy_q + b_sqz_q;
      c_side_q <= b_side_q;
    end
  end

  logic [31:0] root;
  side_t       sd_q [ucp_pkg::SQRT_STAGES];

  ucp_isqrt u_isqrt (
    .clk_i  (clk_i),
    .en_i   (en),
    .sum_i  (c_sum_q),
    .root_o (root)
  );

  always_ff @(posedge clk_i) begin
    if (en) begin
      sd_q[0] <= c_side_q;
      for (int k = 1; k < ucp_pkg::SQRT_STAGES; k++) begin
        sd_q[k] <= sd_q[k-1];
      end
    end
  end

  // stage e: xi times distance
  logic [47:0] e_xd_q;
  side_t       e_side_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      e_xd_q   <= 48'(mirror_xi_q) * 48'(root);
      e_side_q <= sd_q[ucp_pkg::SQRT_STAGES-1];
    end
  end

  // stage f: denominator
  logic [34:0] f_den_q;
  side_t       f_side_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      f_den_q  <= 35'(e_side_q.az) + 35'(e_xd_q[47:14]);
      f_side_q <= e_side_q;
    end
  end

  // stage g: rounding dividends
  logic [57:0] g_dvd_x_q, g_dvd_y_q;
  logic [35:0] g_dsr_q;
  flag_t       g_flag_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      g_dvd_x_q          <= {1'b0, f_side_q.num_x, 1'b0} + 58'(f_den_q);
      g_dvd_y_q          <= {1'b0, f_side_q.num_y, 1'b0} + 58'(f_den_q);
      g_dsr_q            <= {f_den_q, 1'b0};
      g_flag_q.x_neg     <= f_side_q.x_neg;
      g_flag_q.y_neg     <= f_side_q.y_neg;
      g_flag_q.lvl       <= f_side_q.lvl;
      g_flag_q.depth_bad <= f_side_q.depth_bad;
    end
  end

  logic [ucp_pkg::QUOT_BITS-1:0] qx, qy;
  logic                          ovf_x, ovf_y;
  flag_t                         fl_q [ucp_pkg::DIV_STAGES];

  ucp_divider u_div_x (
    .clk_i      (clk_i),
    .en_i       (en),
    .dividend_i (g_dvd_x_q),
    .divisor_i  (g_dsr_q),
    .quot_o     (qx),
    .ovf_o      (ovf_x)
  );

  ucp_divider u_div_y (
    .clk_i      (clk_i),
    .en_i       (en),
    .dividend_i (g_dvd_y_q),
    .divisor_i  (g_dsr_q),
    .quot_o     (qy),
    .ovf_o      (ovf_y)
  );

  always_ff @(posedge clk_i) begin
    if (en) begin
      fl_q[0] <= g_flag_q;
      for (int k = 1; k < ucp_pkg::DIV_STAGES; k++) begin
        fl_q[k] <= fl_q[k-1];
      end
    end
  end

  // stage h: pixel at level zero and margin test
  flag_t              fl_h;
  logic signed [27:0] off_x, off_y, u_lvl0, v_lvl0, lo_lim, hi_u, hi_v;
  logic signed [15:0] w_m, h_m;
  logic               ok_u, ok_v;
  logic signed [27:0] h_u_q, h_v_q;
  ucp_pkg::status_e   h_st_q;
  logic [2:0]         h_lvl_q;

  assign fl_h   = fl_q[ucp_pkg::DIV_STAGES-1];
  assign off_x  = fl_h.x_neg ? -$signed({2'b00, qx}) : $signed({2'b00, qx});
  assign off_y  = fl_h.y_neg ? -$signed({2'b00, qy}) : $signed({2'b00, qy});
  assign u_lvl0 = $signed({4'b0000, center_x_q}) + off_x;
  assign v_lvl0 = $signed({4'b0000, center_y_q}) + off_y;
  assign w_m    = $signed({2'b00, image_width_q})  -
                  $signed(16'(ucp_pkg::BORDER_MARGIN));
  assign h_m    = $signed({2'b00, image_height_q}) -
                  $signed(16'(ucp_pkg::BORDER_MARGIN));
  assign lo_lim = $signed({12'd0, 8'(ucp_pkg::BORDER_MARGIN), 8'h00});
  assign hi_u   = {{4{w_m[15]}}, w_m, 8'h00};
  assign hi_v   = {{4{h_m[15]}}, h_m, 8'h00};
  assign ok_u   = !ovf_x && (u_lvl0 >= lo_lim) && (u_lvl0 < hi_u);
  assign ok_v   = !ovf_y && (v_lvl0 >= lo_lim) && (v_lvl0 < hi_v);

  always_ff @(posedge clk_i) begin
    if (en) begin
      h_u_q   <= u_lvl0;
      h_v_q   <= v_lvl0;
      h_lvl_q <= fl_h.lvl;
      if (fl_h.depth_bad) begin
        h_st_q <= ucp_pkg::ST_DEPTH;
      end else if (!(ok_u && ok_v)) begin
        h_st_q <= ucp_pkg::ST_MARGIN;
      end else begin
        h_st_q <= ucp_pkg::ST_OK;
      end
    end
  end

  // stage i: level scaling into the output register
  ucp_pkg::out_item_t out_q;
  logic [27:0]        su, sv;

  assign su = 28'(h_u_q) >> h_lvl_q;
  assign sv = 28'(h_v_q) >> h_lvl_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q.status  <= h_st_q;
      out_q.pixel_u <= (h_st_q == ucp_pkg::ST_OK) ? su[23:0] : 24'd0;
      out_q.pixel_v <= (h_st_q == ucp_pkg::ST_OK) ? sv[23:0] : 24'd0;
    end
  end

  assign out_data_o = out_q;

  // a rejected item carries a zero pixel
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status != ucp_pkg::ST_OK |->
      out_data_o.pixel_u == 24'd0 && out_data_o.pixel_v == 24'd0)
    else $error("rejected item with nonzero pixel");

  // both coordinates of a projected pixel fit in the 14-bit image size range
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status == ucp_pkg::ST_OK |->
      out_data_o.pixel_u[23:22] == 2'd0 && out_data_o.pixel_v[23:22] == 2'd0)
    else $error("projected pixel beyond image range");

  // a held result stays in place while the pipeline stalls
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("output changed during stall");

endmodule
